// File: design/coap_hdr_pkg.sv
// Shared types and constants of the CoAP-over-TCP response header checker.
package coap_hdr_pkg;

  // Widest frame byte counter that any supported frame limit needs.
  localparam int FRAME_CNT_W = 21;
  localparam int HDR_END_W   = FRAME_CNT_W + 1;
  localparam int BODY_LEN_W  = 33;
  localparam int OPT_START_W = 17;
  localparam int CMP_W       = BODY_LEN_W + 1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TOKEN_LEN = 2'd0;
  localparam logic [1:0] CFG_TOKEN     = 2'd1;

  // Length nibble codes that announce an extended length field.
  localparam logic [3:0] LEN_EXT1 = 4'd13;
  localparam logic [3:0] LEN_EXT2 = 4'd14;
  localparam logic [3:0] MAX_TKL  = 4'd8;

  // Offsets added to the extended length field.
  localparam logic [16:0] EXT1_OFFSET = 17'd13;
  localparam logic [16:0] EXT2_OFFSET = 17'd269;
  localparam logic [16:0] EXT4_OFFSET = 17'd65805;

  // Verdict codes.
  localparam logic [1:0] VERDICT_INVALID = 2'd0;
  localparam logic [1:0] VERDICT_SUCCESS = 2'd1;
  localparam logic [1:0] VERDICT_ERROR   = 2'd2;
  localparam logic [1:0] VERDICT_SIGNAL  = 2'd3;

  // Code classes.
  localparam logic [2:0] CLASS_SUCCESS   = 3'd2;
  localparam logic [2:0] CLASS_CLIENT    = 3'd4;
  localparam logic [2:0] CLASS_SERVER    = 3'd5;
  localparam logic [2:0] CLASS_SIGNAL    = 3'd7;

  // Summary of one finished frame, passed from the parser to the verdict stage.
  typedef struct packed {
    logic                   header_ok;
    logic [7:0]             code;
    logic [BODY_LEN_W-1:0]  body_len;
    logic [HDR_END_W-1:0]   header_end;
    logic [FRAME_CNT_W-1:0] frame_len;
  } frame_summary_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// File: design/coap_hdr_front.sv
// Byte parser: walks the frame header and emits one summary per frame.
module coap_hdr_front
  import coap_hdr_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 65536
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     rx_byte,
  input  logic           end_of_frame,
  input  logic [3:0]     exp_token_len,
  input  logic [63:0]    exp_token,
  output logic           push,
  output frame_summary_t summary
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int HE_W  = CNT_W + 1;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_EXT,
    PH_CODE,
    PH_TOKEN,
    PH_BODY
  } phase_t;

  phase_t                phase, phase_next;
  logic [CNT_W-1:0]      byte_count, byte_count_next;
  logic [2:0]            ext_left, ext_left_next;
  logic [3:0]            tkl, tkl_next;
  logic [3:0]            tok_idx, tok_idx_next;
  logic [BODY_LEN_W-1:0] dec_len, dec_len_next;
  logic [HE_W-1:0]       hdr_end, hdr_end_next;
  logic [7:0]            code, code_next;
  logic                  err, err_next;

  logic                  cnt_full;
  logic [31:0]           shifted;
  logic [16:0]           ext_offset;
  logic [7:0]            want;

  always_comb begin
    cnt_full        = byte_count >= CNT_W'(MAX_FRAME_BYTES);
    err_next        = err | cnt_full;
    byte_count_next = cnt_full ? byte_count : byte_count + 1'b1;
    phase_next      = phase;
    ext_left_next   = ext_left;
    tkl_next        = tkl;
    tok_idx_next    = tok_idx;
    dec_len_next    = dec_len;
    hdr_end_next    = hdr_end;
    code_next       = code;
    shifted         = {dec_len[23:0], rx_byte};
    want            = exp_token[{~tok_idx[2:0], 3'b000} +: 8];
    if (byte_count_next == CNT_W'(2)) begin
      ext_offset = EXT1_OFFSET;
    end else if (byte_count_next == CNT_W'(3)) begin
      ext_offset = EXT2_OFFSET;
    end else begin
      ext_offset = EXT4_OFFSET;
    end
    unique case (phase)
      PH_HEADER: begin
        tkl_next = rx_byte[3:0];
        if (rx_byte[3:0] != exp_token_len || rx_byte[3:0] > MAX_TKL) begin
          err_next = 1'b1;
        end
        if (rx_byte[7:4] < LEN_EXT1) begin
          dec_len_next = BODY_LEN_W'(rx_byte[7:4]);
          phase_next   = PH_CODE;
        end else begin
          dec_len_next = '0;
          if (rx_byte[7:4] == LEN_EXT1) begin
            ext_left_next = 3'd1;
          end else if (rx_byte[7:4] == LEN_EXT2) begin
            ext_left_next = 3'd2;
          end else begin
            ext_left_next = 3'd4;
          end
          phase_next = PH_EXT;
        end
      end
      PH_EXT: begin
        ext_left_next = (ext_left != 3'd0) ? ext_left - 1'b1 : ext_left;
        if (ext_left_next == 3'd0) begin
          dec_len_next = {1'b0, shifted} + BODY_LEN_W'(ext_offset);
          phase_next   = PH_CODE;
        end else begin
          dec_len_next = {1'b0, shifted};
        end
      end
      PH_CODE: begin
        code_next    = rx_byte;
        hdr_end_next = HE_W'(byte_count_next) + HE_W'(tkl);
        if (tkl == 4'd0) begin
          phase_next = PH_BODY;
        end else begin
          tok_idx_next = 4'd0;
          phase_next   = PH_TOKEN;
        end
      end
      PH_TOKEN: begin
        if (!tok_idx[3] && want != rx_byte) begin
          err_next = 1'b1;
        end
        tok_idx_next = tok_idx + 1'b1;
        if (tok_idx_next == tkl) begin
          phase_next = PH_BODY;
        end
      end
      default: begin
      end
    endcase
  end

  assign push = accept && end_of_frame;

  always_comb begin
    summary.header_ok  = !err_next && (phase_next == PH_BODY);
    summary.code       = code_next;
    summary.body_len   = dec_len_next;
    summary.header_end = HDR_END_W'(hdr_end_next);
    summary.frame_len  = FRAME_CNT_W'(byte_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      phase      <= PH_HEADER;
      byte_count <= '0;
      ext_left   <= '0;
      tkl        <= '0;
      tok_idx    <= '0;
      dec_len    <= '0;
      hdr_end    <= '0;
      code       <= '0;
      err        <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      ext_left   <= ext_left_next;
      tkl        <= tkl_next;
      tok_idx    <= tok_idx_next;
      dec_len    <= dec_len_next;
      hdr_end    <= hdr_end_next;
      code       <= code_next;
      err        <= err_next;
    end
  end

endmodule

// File: design/coap_hdr_queue.sv
// Two-entry queue of frame summaries between the parser and the verdict stage.
module coap_hdr_queue
  import coap_hdr_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  frame_summary_t push_data,
  input  logic           pop,
  output frame_summary_t head,
  output queue_status_t  status
);

  frame_summary_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign status.full  = count == 2'd2;
  assign status.empty = count == 2'd0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// File: design/coap_hdr_back.sv
// Verdict stage: checks the declared length, classifies the code, holds the result.
module coap_hdr_back
  import coap_hdr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  frame_summary_t         head,
  input  queue_status_t          status,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             verdict,
  output logic [7:0]             response_code,
  output logic [BODY_LEN_W-1:0]  body_length,
  output logic [OPT_START_W-1:0] options_start
);

  logic [CMP_W-1:0] need_len;
  logic [CMP_W-1:0] start_diff;
  logic             fits;
  logic [1:0]       verdict_calc;

  always_comb begin
    need_len   = CMP_W'(head.header_end) + CMP_W'(head.body_len);
    start_diff = CMP_W'(head.frame_len) - CMP_W'(head.body_len);
    fits       = head.header_ok && (need_len <= CMP_W'(head.frame_len));
    verdict_calc = VERDICT_INVALID;
    if (fits) begin
      unique case (head.code[7:5])
        CLASS_SUCCESS:               verdict_calc = VERDICT_SUCCESS;
        CLASS_CLIENT, CLASS_SERVER:  verdict_calc = VERDICT_ERROR;
        CLASS_SIGNAL:                verdict_calc = VERDICT_SIGNAL;
        default:                     verdict_calc = VERDICT_INVALID;
      endcase
    end
  end

  assign pop = !status.empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      verdict <= verdict_calc;
      if (verdict_calc != VERDICT_INVALID) begin
        response_code <= head.code;
        body_length   <= head.body_len;
        options_start <= start_diff[OPT_START_W-1:0];
      end else begin
        response_code <= '0;
        body_length   <= '0;
        options_start <= '0;
      end
    end
  end

endmodule

// File: design/coap_hdr_checker_top.sv
// Top level of the CoAP-over-TCP response header checker.
//
// The input channel carries one received frame byte per beat on rx_byte,
// with end_of_frame set on the final byte. A beat is taken on a rising
// edge where in_valid is high and in_stall is low. The parser
// updates its header state once per byte.
// Only the final byte of a frame produces a result beat on the output
// channel: verdict, response_code, body_length and options_start. The
// edge that takes the final byte also writes the frame summary into a
// two-entry queue; the output register is then loaded from the queue
// head after the length check and class decode, once the output is
// free of a stalled result.
// One byte per cycle, with back-to-back frames, while in_stall is low.
// While the receiver holds out_stall, the result holds steady; the
// queue absorbs two more finished frames, and only then does in_stall
// rise, stalling the byte stream.
// The configuration channel writes expected_token_length (index 0) and
// expected_token (index 1); cfg_ready is always high.
// Synchronous reset clears the parser, the queue, the output valid and
// both configuration registers; the block is ready right after reset.
module coap_tcp_response_header_checker_core
  import coap_hdr_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 65536
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             rx_byte,
  input  logic                   end_of_frame,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             verdict,
  output logic [7:0]             response_code,
  output logic [BODY_LEN_W-1:0]  body_length,
  output logic [OPT_START_W-1:0] options_start,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [63:0]            cfg_data
);

  // Configuration registers; writes to unused indexes are dropped.
  logic [3:0]     expected_token_length;
  logic [63:0]    expected_token;

  logic           accept;
  logic           push;
  logic           pop;
  frame_summary_t summary;
  frame_summary_t head;
  queue_status_t  q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_token_length <= '0;
      expected_token        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_TOKEN_LEN) begin
        expected_token_length <= cfg_data[3:0];
      end else if (cfg_index == CFG_TOKEN) begin
        expected_token <= cfg_data;
      end
    end
  end

  // Bytes are held off only when the summary queue has no room for a
  // frame that might end on this byte.
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  coap_hdr_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .rx_byte      (rx_byte),
    .end_of_frame (end_of_frame),
    .exp_token_len(expected_token_length),
    .exp_token    (expected_token),
    .push         (push),
    .summary      (summary)
  );

  coap_hdr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(summary),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  coap_hdr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .status       (q_status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .verdict      (verdict),
    .response_code(response_code),
    .body_length  (body_length),
    .options_start(options_start)
  );

endmodule
